// File: sv/sfp_pkg.sv
package sfp_pkg;

  // APB address width: eight 32-bit registers at 4-byte spacing
  localparam int ADDR_W = 5;

  // Rotation coefficients carry a fixed 16-bit fraction
  localparam int TRIG_BITS = 16;

  // Gain numerator of the pole strength
  localparam logic [12:0] GAIN_NUM = 13'd5000;

  // Pole-term divider: 62 quotient bits plus one setup stage
  localparam int DIV_STEPS = 62;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int DEN_W     = 96;
  localparam logic [DIV_STEPS-1:0] TERM_LIM = {DIV_STEPS{1'b1}};

  // Integer square root: one result bit per stage
  localparam int ISQRT_STEPS = 32;
  localparam int SQ_W        = 64;

  typedef enum logic [2:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_COS     = 3'd2,
    REG_SIN     = 3'd3,
    REG_LENGTH  = 3'd4,
    REG_TURNS   = 3'd5,
    REG_RADIUS  = 3'd6,
    REG_CURRENT = 3'd7
  } reg_idx_t;

  // Item state alongside the square-root stages
  typedef struct packed {
    logic              sat;
    logic              pole;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic [SQ_W-1:0]   s1;
    logic [SQ_W-1:0]   s2;
  } meta_t;

  // Item state alongside the divider stages
  typedef struct packed {
    logic sat;
    logic pole;
    logic xneg;
    logic y1neg;
    logic y2neg;
  } sign_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic               saturated;
    logic               on_pole;
  } out_t;

endpackage

// File: sv/sfp_chan_if.sv
interface sfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;

  modport source (output valid, output query_x, output query_y, input ready);
  modport sink (input valid, input query_x, input query_y, output ready);
endinterface

interface sfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] field_x;
  logic signed [31:0] field_y;
  logic               saturated;
  logic               on_pole;

  modport source (output valid, output field_x, output field_y, output saturated,
                  output on_pole, input ready);
  modport sink (input valid, input field_x, input field_y, input saturated,
                input on_pole, output ready);
endinterface

// File: sv/sfp_isqrt.sv
module sfp_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sfp_pkg::SQ_W-1:0]    s_in,
  output logic [31:0]                 root
);

  localparam int N = sfp_pkg::ISQRT_STEPS;
  localparam int W = sfp_pkg::SQ_W;

  logic [W-1:0] s_r [N];
  logic [W-1:0] res_r [N];
  logic [W-1:0] s_src [N];
  logic [W-1:0] res_src [N];
  logic [W-1:0] trial [N];
  logic [W-1:0] bitv [N];
  logic [W-1:0] s_nxt [N];
  logic [W-1:0] res_nxt [N];

  // One digit-pair per stage, highest first
  always_comb begin
    s_src[0]   = s_in;
    res_src[0] = '0;
    for (int i = 1; i < N; i++) begin
      s_src[i]   = s_r[i-1];
      res_src[i] = res_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      bitv[i]  = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * i);
      trial[i] = res_src[i] + bitv[i];
      if (s_src[i] >= trial[i]) begin
        s_nxt[i]   = s_src[i] - trial[i];
        res_nxt[i] = (res_src[i] >> 1) + bitv[i];
      end else begin
        s_nxt[i]   = s_src[i];
        res_nxt[i] = res_src[i] >> 1;
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        s_r[i]   <= s_nxt[i];
        res_r[i] <= res_nxt[i];
      end
    end
  end

  assign root = res_r[N-1][31:0];

endmodule

// File: sv/sfp_div.sv
module sfp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [31:0]                      num_mag,
  input  logic [sfp_pkg::DEN_W-1:0]        den,
  output logic [sfp_pkg::DIV_STEPS-1:0]    quo,
  output logic                             ovf
);

  localparam int QW   = sfp_pkg::DIV_STEPS;
  localparam int DW   = sfp_pkg::DEN_W;
  localparam int STG  = sfp_pkg::DIV_LAT;
  localparam int NW   = 32 + 4 * FRAC_BITS;
  localparam int HIW  = NW - QW;
  localparam int PADW = DW - HIW;

  logic [NW-1:0] n_full;
  logic [DW-1:0] rem_init;

  logic [DW-1:0] rem_r [STG];
  logic [DW-1:0] den_r [STG];
  logic [QW-1:0] lo_r [STG];
  logic [QW-1:0] q_r [STG];
  logic          ovf_r [STG];

  logic [DW-1:0] rem_nxt [STG];
  logic [DW-1:0] den_nxt [STG];
  logic [QW-1:0] lo_nxt [STG];
  logic [QW-1:0] q_nxt [STG];
  logic          ovf_nxt [STG];
  logic [DW:0]   rem_sh [STG];
  logic [DW:0]   diff [STG];
  logic          ge [STG];

  // Numerator is the magnitude scaled up by four fraction widths
  assign n_full   = {num_mag, {(4 * FRAC_BITS){1'b0}}};
  assign rem_init = {{PADW{1'b0}}, n_full[NW-1:QW]};

  always_comb begin
    // Setup: flag quotients that cannot fit the term range
    rem_nxt[0] = rem_init;
    den_nxt[0] = den;
    lo_nxt[0]  = n_full[QW-1:0];
    q_nxt[0]   = '0;
    ovf_nxt[0] = (rem_init >= den);
    rem_sh[0]  = '0;
    diff[0]    = '0;
    ge[0]      = 1'b0;
    // Restoring steps, one quotient bit each
    for (int i = 1; i < STG; i++) begin
      rem_sh[i]  = {rem_r[i-1], lo_r[i-1][QW-1]};
      diff[i]    = rem_sh[i] - {1'b0, den_r[i-1]};
      ge[i]      = (rem_sh[i] >= {1'b0, den_r[i-1]});
      rem_nxt[i] = ge[i] ? diff[i][DW-1:0] : rem_sh[i][DW-1:0];
      den_nxt[i] = den_r[i-1];
      lo_nxt[i]  = {lo_r[i-1][QW-2:0], 1'b0};
      q_nxt[i]   = {q_r[i-1][QW-2:0], ge[i]};
      ovf_nxt[i] = ovf_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STG; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_nxt[i];
        lo_r[i]  <= lo_nxt[i];
        q_r[i]   <= q_nxt[i];
        ovf_r[i] <= ovf_nxt[i];
      end
    end
  end

  assign quo = q_r[STG-1];
  assign ovf = ovf_r[STG-1];

endmodule

// File: sv/solenoid_field_at_point.sv
// Two-pole solenoid field evaluator. Each query point (signed Q16.16) is
// shifted by the solenoid center, rotated into the coil frame, and the two
// pole contributions are scaled by the coil gain and rotated back to world
// axes; results are saturating Q16.16 with a saturation flag, and a point
// exactly on a pole returns zero with on_pole set. The pipeline takes one
// query per clock while its input is ready; its depth is set by the
// 32-stage square root and the 63-stage pole-term divider. An output
// register plus a skid entry keep the input ready while one result waits.
// Configuration registers must be written over APB only while no query is
// in flight; the block itself does not enforce this. The coil gain is
// recomputed from them by a free-running register pipeline.
module solenoid_field_at_point #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sfp_in_if.sink                      in_ch,
  sfp_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int TB   = sfp_pkg::TRIG_BITS;
  localparam int NSQ  = sfp_pkg::ISQRT_STEPS;
  localparam int NDV  = sfp_pkg::DIV_LAT;
  localparam int LAT  = 6 + NSQ + 2 + NDV + 7;
  localparam int G    = 2 * FRAC_BITS;
  localparam int KSH  = 2 * FRAC_BITS + 2;
  localparam int KWW  = 123 - KSH;
  localparam int PW   = 126 - G;

  function automatic logic [32:0] clamp32(input logic signed [63:0] v);
    logic [32:0] res;
    if (v > 64'sd2147483647) res = {1'b1, 32'h7FFF_FFFF};
    else if (v < -64'sd2147483648) res = {1'b1, 32'h8000_0000};
    else res = {1'b0, v[31:0]};
    return res;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] res;
    res = v[31] ? (~v + 32'd1) : v;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] pos_x_r, pos_y_r, cur_r;
  logic signed [17:0] cos_r, sin_r;
  logic [30:0]        len_r, rad_r;
  logic [15:0]        turns_r;
  logic               cfg_wr;
  sfp_pkg::reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = sfp_pkg::reg_idx_t'(paddr[4:2]);

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      cos_r   <= 18'sd65536;
      sin_r   <= '0;
      len_r   <= '0;
      turns_r <= '0;
      rad_r   <= '0;
      cur_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sfp_pkg::REG_POS_X:   pos_x_r <= pwdata;
        sfp_pkg::REG_POS_Y:   pos_y_r <= pwdata;
        sfp_pkg::REG_COS:     cos_r   <= pwdata[17:0];
        sfp_pkg::REG_SIN:     sin_r   <= pwdata[17:0];
        sfp_pkg::REG_LENGTH:  len_r   <= pwdata[30:0];
        sfp_pkg::REG_TURNS:   turns_r <= pwdata[15:0];
        sfp_pkg::REG_RADIUS:  rad_r   <= pwdata[30:0];
        sfp_pkg::REG_CURRENT: cur_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      sfp_pkg::REG_POS_X:   prdata = pos_x_r;
      sfp_pkg::REG_POS_Y:   prdata = pos_y_r;
      sfp_pkg::REG_COS:     prdata = 32'(cos_r);
      sfp_pkg::REG_SIN:     prdata = 32'(sin_r);
      sfp_pkg::REG_LENGTH:  prdata = 32'(len_r);
      sfp_pkg::REG_TURNS:   prdata = 32'(turns_r);
      sfp_pkg::REG_RADIUS:  prdata = 32'(rad_r);
      sfp_pkg::REG_CURRENT: prdata = cur_r;
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Coil gain: free-running pipeline over the static registers
  // ---------------------------------------------------------------------
  logic [44:0]  ka_r;
  logic [61:0]  rr_r, rr2_r;
  logic [60:0]  kb_r;
  logic [63:0]  kll_r;
  logic [61:0]  klh_r;
  logic [60:0]  khl_r;
  logic [58:0]  khh_r;
  logic [122:0] kprod_r;
  logic [62:0]  kmag_r;
  logic         ksat_r;
  logic [KWW-1:0] kw;
  logic           kovf;

  assign kw   = kprod_r[122:KSH];
  assign kovf = |kw[KWW-1:63];

  always_ff @(posedge clk) begin
    ka_r    <= 45'(sfp_pkg::GAIN_NUM) * 45'(mag32(cur_r));
    rr_r    <= 62'(rad_r) * 62'(rad_r);
    kb_r    <= 61'(ka_r) * 61'(turns_r);
    rr2_r   <= rr_r;
    kll_r   <= 64'(kb_r[31:0]) * 64'(rr2_r[31:0]);
    klh_r   <= 62'(kb_r[31:0]) * 62'(rr2_r[61:32]);
    khl_r   <= 61'(kb_r[60:32]) * 61'(rr2_r[31:0]);
    khh_r   <= 59'(kb_r[60:32]) * 59'(rr2_r[61:32]);
    kprod_r <= 123'(kll_r) + (123'(klh_r) << 32) + (123'(khl_r) << 32)
             + (123'(khh_r) << 64);
    kmag_r  <= kovf ? {63{1'b1}} : kw[62:0];
    ksat_r  <= kovf;
  end

  // ---------------------------------------------------------------------
  // Flow control: whole pipeline advances unless the skid entry is full
  // ---------------------------------------------------------------------
  logic           adv, in_fire;
  logic [LAT-1:0] vld_r;
  logic           out_v_r, skid_v_r;
  sfp_pkg::out_t  out_d_r, skid_d_r, res_c;

  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid & adv;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_fire};
  end

  // ---------------------------------------------------------------------
  // Front: translate, rotate, clamp, square
  // ---------------------------------------------------------------------
  logic signed [32:0] dx_r, dy_r;
  logic signed [50:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic signed [51:0] xs_r, ys_r;
  logic signed [35:0] xr, yr;
  logic signed [31:0] hlf;
  logic [32:0]        cx, cy1, cy2;
  logic signed [31:0] x1_r, y1_r, y2_r;
  logic               sat4_r;
  logic signed [31:0] x1b_r, y1b_r, y2b_r;
  logic [63:0]        x1sq_r, y1sq_r, y2sq_r;
  logic               sat5_r, pole5_r;
  sfp_pkg::meta_t     s6_r;

  assign xr  = signed'(xs_r[51:TB]);
  assign yr  = signed'(ys_r[51:TB]);
  assign hlf = signed'(32'(len_r[30:1]));
  assign cx  = clamp32(64'(xr));
  assign cy1 = clamp32(64'(yr) - 64'(hlf));
  assign cy2 = clamp32(64'(yr) + 64'(hlf));

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= 33'(in_ch.query_x) - 33'(pos_x_r);
      dy_r   <= 33'(in_ch.query_y) - 33'(pos_y_r);
      pxc_r  <= 51'(dx_r) * 51'(cos_r);
      pys_r  <= 51'(dy_r) * 51'(sin_r);
      pyc_r  <= 51'(dy_r) * 51'(cos_r);
      pxs_r  <= 51'(dx_r) * 51'(sin_r);
      xs_r   <= 52'(pxc_r) + 52'(pys_r);
      ys_r   <= 52'(pyc_r) - 52'(pxs_r);
      x1_r   <= cx[31:0];
      y1_r   <= cy1[31:0];
      y2_r   <= cy2[31:0];
      sat4_r <= cx[32] | cy1[32] | cy2[32];
      x1sq_r <= 64'(x1_r) * 64'(x1_r);
      y1sq_r <= 64'(y1_r) * 64'(y1_r);
      y2sq_r <= 64'(y2_r) * 64'(y2_r);
      x1b_r  <= x1_r;
      y1b_r  <= y1_r;
      y2b_r  <= y2_r;
      sat5_r <= sat4_r;
      pole5_r <= (x1_r == 32'sd0) && ((y1_r == 32'sd0) || (y2_r == 32'sd0));
      s6_r.s1   <= x1sq_r + y1sq_r;
      s6_r.s2   <= x1sq_r + y2sq_r;
      s6_r.x1   <= x1b_r;
      s6_r.y1   <= y1b_r;
      s6_r.y2   <= y2b_r;
      s6_r.sat  <= sat5_r;
      s6_r.pole <= pole5_r;
    end
  end

  // ---------------------------------------------------------------------
  // Distance to each pole
  // ---------------------------------------------------------------------
  logic [31:0]    r1, r2;
  sfp_pkg::meta_t dlyb_r [NSQ];
  sfp_pkg::meta_t mb;

  sfp_isqrt u_sqrt1 (.clk(clk), .en(adv), .s_in(s6_r.s1), .root(r1));
  sfp_isqrt u_sqrt2 (.clk(clk), .en(adv), .s_in(s6_r.s2), .root(r2));

  always_ff @(posedge clk) begin
    if (adv) begin
      dlyb_r[0] <= s6_r;
      for (int i = 1; i < NSQ; i++) dlyb_r[i] <= dlyb_r[i-1];
    end
  end

  assign mb = dlyb_r[NSQ-1];

  // ---------------------------------------------------------------------
  // Divisor s*r in two halves, then combine
  // ---------------------------------------------------------------------
  logic [63:0]          pl1_r, ph1_r, pl2_r, ph2_r;
  logic [31:0]          mx_r, my1_r, my2_r, mx2_r, my12_r, my22_r;
  sfp_pkg::sign_t       c1_r, c2_r;
  logic [sfp_pkg::DEN_W-1:0] d1_r, d2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pl1_r <= 64'(mb.s1[31:0]) * 64'(r1);
      ph1_r <= 64'(mb.s1[63:32]) * 64'(r1);
      pl2_r <= 64'(mb.s2[31:0]) * 64'(r2);
      ph2_r <= 64'(mb.s2[63:32]) * 64'(r2);
      mx_r  <= mag32(mb.x1);
      my1_r <= mag32(mb.y1);
      my2_r <= mag32(mb.y2);
      c1_r.sat   <= mb.sat;
      c1_r.pole  <= mb.pole;
      c1_r.xneg  <= mb.x1[31];
      c1_r.y1neg <= mb.y1[31];
      c1_r.y2neg <= mb.y2[31];
      d1_r   <= 96'(pl1_r) + {ph1_r, 32'h0};
      d2_r   <= 96'(pl2_r) + {ph2_r, 32'h0};
      mx2_r  <= mx_r;
      my12_r <= my1_r;
      my22_r <= my2_r;
      c2_r   <= c1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Pole terms c * r^-3
  // ---------------------------------------------------------------------
  logic [sfp_pkg::DIV_STEPS-1:0] qx1, qx2, qy1, qy2;
  logic                          ox1, ox2, oy1, oy2;
  sfp_pkg::sign_t                dlyd_r [NDV];
  sfp_pkg::sign_t                md;

  sfp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x1 (
    .clk(clk), .en(adv), .num_mag(mx2_r), .den(d1_r), .quo(qx1), .ovf(ox1));
  sfp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x2 (
    .clk(clk), .en(adv), .num_mag(mx2_r), .den(d2_r), .quo(qx2), .ovf(ox2));
  sfp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y1 (
    .clk(clk), .en(adv), .num_mag(my12_r), .den(d1_r), .quo(qy1), .ovf(oy1));
  sfp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y2 (
    .clk(clk), .en(adv), .num_mag(my22_r), .den(d2_r), .quo(qy2), .ovf(oy2));

  always_ff @(posedge clk) begin
    if (adv) begin
      dlyd_r[0] <= c2_r;
      for (int i = 1; i < NDV; i++) dlyd_r[i] <= dlyd_r[i-1];
    end
  end

  assign md = dlyd_r[NDV-1];

  // ---------------------------------------------------------------------
  // Back end: differences, gain, rotate to world
  // ---------------------------------------------------------------------
  logic [61:0]        mtx1, mtx2, mty1, mty2;
  logic signed [63:0] tx1_r, tx2_r, ty1_r, ty2_r;
  logic signed [63:0] ddx_r, ddy_r, ndx, ndy;
  logic [62:0]        dmx_r, dmy_r;
  logic               negx_r, negy_r, negx4_r, negy4_r, negx5_r, negy5_r;
  logic               sat1_r, sat2_r, sat3_r, satt4_r, satt5_r, sat6_r, sat7_r;
  logic               pl1f_r, pl2f_r, pl3f_r, pl4f_r, pl5f_r, pl6f_r, pl7f_r;
  logic [63:0]        xll_r, yll_r;
  logic [62:0]        xlh_r, xhl_r, ylh_r, yhl_r;
  logic [61:0]        xhh_r, yhh_r;
  logic [125:0]       xprod_r, yprod_r;
  logic [PW-1:0]      px, py;
  logic [31:0]        limx, limy, bmx, bmy;
  logic               ovx, ovy;
  logic signed [31:0] bx_r, by_r;
  logic signed [49:0] bxc_r, bys_r, byc_r, bxs_r;
  logic signed [50:0] fxw, fyw;
  logic [32:0]        cfx, cfy;

  assign mtx1 = ox1 ? sfp_pkg::TERM_LIM : qx1;
  assign mtx2 = ox2 ? sfp_pkg::TERM_LIM : qx2;
  assign mty1 = oy1 ? sfp_pkg::TERM_LIM : qy1;
  assign mty2 = oy2 ? sfp_pkg::TERM_LIM : qy2;
  assign ndx  = -ddx_r;
  assign ndy  = -ddy_r;

  // Clamp the scaled field per axis; negative side reaches one further
  assign px   = xprod_r[125:G];
  assign py   = yprod_r[125:G];
  assign limx = negx5_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign limy = negy5_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign ovx  = (px > PW'(limx));
  assign ovy  = (py > PW'(limy));
  assign bmx  = ovx ? limx : px[31:0];
  assign bmy  = ovy ? limy : py[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      // Signed pole terms
      tx1_r  <= md.xneg ? -64'(mtx1) : 64'(mtx1);
      tx2_r  <= md.xneg ? -64'(mtx2) : 64'(mtx2);
      ty1_r  <= md.y1neg ? -64'(mty1) : 64'(mty1);
      ty2_r  <= md.y2neg ? -64'(mty2) : 64'(mty2);
      sat1_r <= md.sat | ox1 | ox2 | oy1 | oy2;
      pl1f_r <= md.pole;
      // Pole differences
      ddx_r  <= tx1_r - tx2_r;
      ddy_r  <= ty1_r - ty2_r;
      sat2_r <= sat1_r;
      pl2f_r <= pl1f_r;
      // Magnitude and product sign
      dmx_r  <= ddx_r[63] ? ndx[62:0] : ddx_r[62:0];
      dmy_r  <= ddy_r[63] ? ndy[62:0] : ddy_r[62:0];
      negx_r <= ddx_r[63] ^ cur_r[31];
      negy_r <= ddy_r[63] ^ cur_r[31];
      sat3_r <= sat2_r;
      pl3f_r <= pl2f_r;
      // Gain times difference, partial products
      xll_r  <= 64'(kmag_r[31:0]) * 64'(dmx_r[31:0]);
      xlh_r  <= 63'(kmag_r[31:0]) * 63'(dmx_r[62:32]);
      xhl_r  <= 63'(kmag_r[62:32]) * 63'(dmx_r[31:0]);
      xhh_r  <= 62'(kmag_r[62:32]) * 62'(dmx_r[62:32]);
      yll_r  <= 64'(kmag_r[31:0]) * 64'(dmy_r[31:0]);
      ylh_r  <= 63'(kmag_r[31:0]) * 63'(dmy_r[62:32]);
      yhl_r  <= 63'(kmag_r[62:32]) * 63'(dmy_r[31:0]);
      yhh_r  <= 62'(kmag_r[62:32]) * 62'(dmy_r[62:32]);
      negx4_r <= negx_r;
      negy4_r <= negy_r;
      satt4_r <= sat3_r | ksat_r;
      pl4f_r  <= pl3f_r;
      // Combine partial products
      xprod_r <= 126'(xll_r) + (126'(xlh_r) << 32) + (126'(xhl_r) << 32)
               + (126'(xhh_r) << 64);
      yprod_r <= 126'(yll_r) + (126'(ylh_r) << 32) + (126'(yhl_r) << 32)
               + (126'(yhh_r) << 64);
      negx5_r <= negx4_r;
      negy5_r <= negy4_r;
      satt5_r <= satt4_r;
      pl5f_r  <= pl4f_r;
      // Clamp and apply sign
      bx_r   <= negx5_r ? (~bmx + 32'd1) : bmx;
      by_r   <= negy5_r ? (~bmy + 32'd1) : bmy;
      sat6_r <= satt5_r | ovx | ovy;
      pl6f_r <= pl5f_r;
      // Rotation products back to world axes
      bxc_r  <= 50'(bx_r) * 50'(cos_r);
      bys_r  <= 50'(by_r) * 50'(sin_r);
      byc_r  <= 50'(by_r) * 50'(cos_r);
      bxs_r  <= 50'(bx_r) * 50'(sin_r);
      sat7_r <= sat6_r;
      pl7f_r <= pl6f_r;
    end
  end

  // Final rotation sums and clamp, pole override
  assign fxw = 51'(bxc_r) - 51'(bys_r);
  assign fyw = 51'(byc_r) + 51'(bxs_r);
  assign cfx = clamp32(64'(signed'(fxw[50:TB])));
  assign cfy = clamp32(64'(signed'(fyw[50:TB])));

  always_comb begin
    if (pl7f_r) begin
      res_c.field_x   = '0;
      res_c.field_y   = '0;
      res_c.saturated = 1'b0;
      res_c.on_pole   = 1'b1;
    end else begin
      res_c.field_x   = cfx[31:0];
      res_c.field_y   = cfy[31:0];
      res_c.saturated = sat7_r | cfx[32] | cfy[32];
      res_c.on_pole   = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ch.ready) begin
      // Hold output; park an arriving result
      if (adv && vld_r[LAT-1]) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= adv & vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ch.ready) begin
      if (adv && vld_r[LAT-1]) skid_d_r <= res_c;
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
    end else begin
      out_d_r <= res_c;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.field_x   = out_d_r.field_x;
  assign out_ch.field_y   = out_d_r.field_y;
  assign out_ch.saturated = out_d_r.saturated;
  assign out_ch.on_pole   = out_d_r.on_pole;

endmodule

// File: test/sfp_checker.sv
`timescale 1ns / 100ps

module sfp_checker
  import sfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sfp_in_if                   in_ch,
  sfp_out_if                  out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  fields_pending
);

  // Register shadow, updated from the APB writes seen on the bus
  longint      sh_pos_x, sh_pos_y, sh_cos, sh_sin, sh_current;
  logic [30:0] sh_length, sh_radius;
  logic [15:0] sh_turns;

  out_t field_q[$];

  function automatic longint clamp32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Coordinate over distance cubed, Q.32, magnitude clamped to 2^62-1
  function automatic longint pole_pull(longint c, logic [63:0] s, logic [63:0] r,
                                       inout logic sat);
    logic [127:0] num, den, q;
    logic [63:0]  m;
    num = {abs64(c), 64'd0};
    den = {64'd0, s} * {64'd0, r};
    q = num / den;
    m = q[63:0];
    if (q > 128'h3FFF_FFFF_FFFF_FFFF) begin
      sat = 1'b1;
      m = 64'h3FFF_FFFF_FFFF_FFFF;
    end
    return (c < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint apply_gain(logic [63:0] kmag, logic kneg, longint d,
                                        inout logic sat);
    logic [127:0] p;
    logic [63:0]  m, lim;
    logic         neg;
    p = ({64'd0, kmag} * {64'd0, abs64(d)}) >> 32;
    neg = kneg ^ (d < 0);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    m = p[63:0];
    if (p > {64'd0, lim}) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic out_t field_at(logic signed [31:0] qx, logic signed [31:0] qy);
    out_t         r;
    logic         sat;
    longint       dx, dy, xr, yr, h, x1, y1, y2, ddx, ddy, bx, by;
    logic [63:0]  s1, s2, r1, r2, kmag;
    logic [127:0] kw;
    sat = 1'b0;
    dx = longint'(qx) - sh_pos_x;
    dy = longint'(qy) - sh_pos_y;
    xr = (dx * sh_cos + dy * sh_sin) >>> 16;
    yr = (dy * sh_cos - dx * sh_sin) >>> 16;
    h = longint'({33'd0, sh_length} >> 1);
    x1 = clamp32(xr, sat);
    y1 = clamp32(yr - h, sat);
    y2 = clamp32(yr + h, sat);
    s1 = 64'(x1 * x1) + 64'(y1 * y1);
    s2 = 64'(x1 * x1) + 64'(y2 * y2);
    // Query exactly on a pole: zero field, no saturation
    if (s1 == 0 || s2 == 0) begin
      r = '0;
      r.on_pole = 1'b1;
      return r;
    end
    r1 = root_floor(s1);
    r2 = root_floor(s2);
    ddx = pole_pull(x1, s1, r1, sat) - pole_pull(x1, s2, r2, sat);
    ddy = pole_pull(y1, s1, r1, sat) - pole_pull(y2, s2, r2, sat);
    kw = ({64'd0, 64'd5000 * abs64(sh_current) * {48'd0, sh_turns}} *
          {64'd0, {33'd0, sh_radius} * {33'd0, sh_radius}}) >> 34;
    kmag = kw[63:0];
    if (kw > 128'h7FFF_FFFF_FFFF_FFFF) begin
      sat = 1'b1;
      kmag = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    bx = apply_gain(kmag, sh_current < 0, ddx, sat);
    by = apply_gain(kmag, sh_current < 0, ddy, sat);
    r.field_x = 32'(clamp32((bx * sh_cos - by * sh_sin) >>> 16, sat));
    r.field_y = 32'(clamp32((by * sh_cos + bx * sh_sin) >>> 16, sat));
    r.saturated = sat;
    r.on_pole = 1'b0;
    return r;
  endfunction

  assign fields_pending = field_q.size();

  always @(posedge clk) begin
    out_t got, want;
    if (!rst_n) begin
      sh_pos_x <= 0;
      sh_pos_y <= 0;
      sh_cos <= 65536;
      sh_sin <= 0;
      sh_length <= '0;
      sh_turns <= '0;
      sh_radius <= '0;
      sh_current <= 0;
      mismatches <= 0;
      field_q.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_POS_X:   sh_pos_x <= longint'($signed(pwdata));
          REG_POS_Y:   sh_pos_y <= longint'($signed(pwdata));
          REG_COS:     sh_cos <= longint'($signed(pwdata[17:0]));
          REG_SIN:     sh_sin <= longint'($signed(pwdata[17:0]));
          REG_LENGTH:  sh_length <= pwdata[30:0];
          REG_TURNS:   sh_turns <= pwdata[15:0];
          REG_RADIUS:  sh_radius <= pwdata[30:0];
          REG_CURRENT: sh_current <= longint'($signed(pwdata));
          default: ;
        endcase
      end
      // Predict each accepted query
      if (in_ch.valid && in_ch.ready)
        field_q.push_back(field_at(in_ch.query_x, in_ch.query_y));
      // Compare each delivered result with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.field_x = out_ch.field_x;
        got.field_y = out_ch.field_y;
        got.saturated = out_ch.saturated;
        got.on_pole = out_ch.on_pole;
        if (field_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transaction: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = field_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("field mismatch: expected x=%0d y=%0d sat=%0b pole=%0b, got x=%0d y=%0d sat=%0b pole=%0b",
                       want.field_x, want.field_y, want.saturated, want.on_pole,
                       got.field_x, got.field_y, got.saturated, got.on_pole);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sfp_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  int                mismatches, fields_pending;
  int                send_idle, recv_idle;
  int                quiet_cycles;

  sfp_in_if  in_ch ();
  sfp_out_if out_ch ();

  solenoid_field_at_point dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sfp_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .mismatches(mismatches),
    .fields_pending(fields_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Random backpressure on the result side
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic coil_setup(logic [31:0] px, logic [31:0] py, int c, int s,
                            logic [31:0] len, logic [31:0] nt, logic [31:0] rad,
                            logic [31:0] cur);
    reg_write(REG_POS_X, px);
    reg_write(REG_POS_Y, py);
    reg_write(REG_COS, 32'(c));
    reg_write(REG_SIN, 32'(s));
    reg_write(REG_LENGTH, len);
    reg_write(REG_TURNS, nt);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_CURRENT, cur);
    // let the gain settle
    repeat (8) @(posedge clk);
  endtask

  // Offer one query at the current edge; valid stays high into the next call
  // so transactions can follow back to back
  task automatic send_query(logic [31:0] qx, logic [31:0] qy);
    logic took;
    // idle the sender cycle by cycle
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.query_x <= qx;
    in_ch.query_y <= qy;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Drop valid at the current edge and wait for every result
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fields_pending != 0) @(posedge clk);
  endtask

  // Query near a pole of the current coil, sometimes exactly on it
  task automatic pole_query(logic [31:0] px, logic [31:0] py, int c, int s,
                            logic [31:0] len, int spread);
    longint yp, qx, qy;
    yp = longint'(len >> 1);
    if ($urandom_range(1)) yp = -yp;
    qx = longint'($signed(px)) - ((longint'(s) * yp) >>> 16);
    qy = longint'($signed(py)) + ((longint'(c) * yp) >>> 16);
    if (spread > 0) begin
      qx = qx + $urandom_range(2 * spread) - spread;
      qy = qy + $urandom_range(2 * spread) - spread;
    end
    send_query(32'(qx), 32'(qy));
  endtask

  initial begin
    logic [31:0] px, py, len, nt, rad, cur;
    int c, s, spread, sel;
    real ang;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.query_x = '0;
    in_ch.query_y = '0;
    out_ch.ready = 1'b0;
    send_idle = 33;
    recv_idle = 87;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: zero length puts both poles at the origin
    send_query(32'h0, 32'h0);
    send_query(32'h0001_0000, 32'h0);
    drain();

    // Directed: unit coil, axis-aligned
    coil_setup(0, 0, 65536, 0, 32'h0002_0000, 100, 32'h0000_8000, 32'h0001_0000);
    send_query(32'h0, 32'h0001_0000);
    send_query(32'h0, 32'hFFFF_0000);
    send_query(32'h0, 32'h0);
    send_query(32'h0000_0001, 32'h0001_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h0003_0000, 32'h0);
    send_query(32'hFFFD_0000, 32'h0002_0000);
    send_query(32'h0000_4000, 32'h0001_4000);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Directed: every register at its extreme, angle off the unit circle
    coil_setup(32'h8000_0000, 32'h7FFF_FFFF, -65536, -65536, 32'h7FFF_FFFF, 16'hFFFF,
               32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h0, 32'h0);
    send_query(32'h1234_5678, 32'h8765_4321);
    drain();
    coil_setup(32'h7FFF_FFFF, 32'h8000_0000, 65536, 65536, 0, 1, 1, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h7FFF_FFFE, 32'h8000_0000);
    send_query(32'h0, 32'h0);
    drain();

    // Random phases: each draws a coil, then mostly near-coil queries
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle = 33;
        recv_idle = 87;
      end else if (ph < 6) begin
        send_idle = 87;
        recv_idle = 33;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      ang = $urandom_range(6283) / 1000.0;
      c = $rtoi($cos(ang) * 65536.0);
      s = $rtoi($sin(ang) * 65536.0);
      sel = $urandom_range(3);
      if (sel == 0) begin
        c = $urandom_range(4) * 32768 - 65536;
        s = $urandom_range(4) * 32768 - 65536;
      end else if (sel == 1) begin
        c = 0;
        s = $urandom_range(1) ? 65536 : -65536;
      end
      px = (ph == 8) ? $urandom : 32'($signed($urandom_range(200000)) - 100000);
      py = (ph == 8) ? $urandom : 32'($signed($urandom_range(200000)) - 100000);
      len = (ph == 7) ? ($urandom >> 1) : 32'($urandom_range(8 << 16));
      nt = (ph == 0) ? 0 : ((ph == 8) ? $urandom : $urandom_range(1, 500));
      rad = (ph == 7) ? 32'h7FFF_FFFF : 32'($urandom_range(1 << 17));
      cur = (ph == 8) ? $urandom : 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      coil_setup(px, py, c, s, len, nt, rad, cur);
      spread = 1 << $urandom_range(20);
      for (int i = 0; i < 150; i++) begin
        sel = $urandom_range(9);
        if (sel < 2)
          pole_query(px, py, c, s, len, 0);
        else if (sel < 7)
          pole_query(px, py, c, s, len, spread);
        else
          send_query($urandom, $urandom);
        // hold off until the pipeline is empty, once mid-run
        if (ph == 4 && i == 75) drain();
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
